/* hw/rtl/lds_pkg.sv */
// Shared types and constants for the linear Diophantine solver.
`default_nettype none
package lds_pkg;

  localparam int LDS_WIDTH = 32;
  localparam int COEF_W    = 31;
  localparam int RHS_W     = 32;
  localparam int DIV_W     = 31;
  localparam int SOL_W     = 64;
  localparam int STATUS_W  = 2;

  typedef enum logic [STATUS_W-1:0] {
    ST_SOLVED = 2'd0,
    ST_NONE   = 2'd1,
    ST_ALL    = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MUL_S1,
    MUL_T1,
    MUL_S0,
    MUL_T0
  } mul_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_go;
    logic     div_rhs;
    logic     mul_en;
    mul_sel_t mul_sel;
    logic     ns_en;
    logic     x_en;
    logic     step;
    logic     finish;
    status_t  fin_status;
  } dp_cmd_t;

  typedef struct packed {
    logic ab_zero;
    logic c_zero;
    logic r1_zero;
    logic div_done;
    logic rem_zero;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/lds_div.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`default_nettype none
module lds_div #(
  parameter int W = 32
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         start,
  input  wire logic [W-1:0] dividend,
  input  wire logic [W-1:0] dvsr,
  output logic              done,
  output logic [W-1:0]      quo,
  output logic [W-1:0]      rem
);

  localparam int CW = $clog2(W);

  logic          running;
  logic [CW-1:0] cnt;
  logic [W-1:0]  dvs;
  logic [W:0]    partial;
  logic          fits;

  assign partial = {rem, quo[W-1]};
  assign fits    = (partial >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CW'(W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= dvsr;
    end else if (running) begin
      if (fits) begin
        rem <= W'(partial - {1'b0, dvs});
      end else begin
        rem <= partial[W-1:0];
      end
      quo <= {quo[W-2:0], fits};
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/lds_datapath.sv */
// Datapath: remainder and Bezout registers, shared divider and multiplier, result registers.
`default_nettype none
module lds_datapath
  import lds_pkg::*;
#(
  parameter int W = LDS_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire dp_cmd_t                 cmd,
  output dp_stat_t                     stat,
  input  wire logic [COEF_W-1:0]       coef_a,
  input  wire logic [COEF_W-1:0]       coef_b,
  input  wire logic signed [RHS_W-1:0] rhs_c,
  output logic                         done,
  output logic [DIV_W-1:0]             divisor,
  output logic signed [SOL_W-1:0]      sol_x,
  output logic signed [SOL_W-1:0]      sol_y,
  output logic [STATUS_W-1:0]          status
);

  logic [W-2:0]        r0, r1;
  logic signed [W-1:0] s0, s1, t0, t1, ns;
  logic signed [W-1:0] c_reg;
  logic                ab_zero, c_zero;
  logic signed [2*W-1:0] prod, xres;

  logic [W-1:0]        div_dividend, div_dvsr, quo, rem;
  logic                div_done;
  logic                c_neg;
  logic [W-1:0]        c_mag;
  logic signed [W-1:0] k, mul_a, mul_b;

  assign c_neg = c_reg[W-1];
  assign c_mag = c_neg ? (W'(0) - c_reg) : c_reg;
  assign k     = c_neg ? (W'(0) - quo) : quo;

  assign div_dividend = cmd.div_rhs ? c_mag : W'(r0);
  assign div_dvsr     = cmd.div_rhs ? W'(r0) : W'(r1);

  lds_div #(.W(W)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_go),
    .dividend (div_dividend),
    .dvsr     (div_dvsr),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  // quotient of a Euclid step, or the scale factor c/g once gcd is known
  always_comb begin
    unique case (cmd.mul_sel)
      MUL_S1: begin mul_a = quo; mul_b = s1; end
      MUL_T1: begin mul_a = quo; mul_b = t1; end
      MUL_S0: begin mul_a = k;   mul_b = s0; end
      MUL_T0: begin mul_a = k;   mul_b = t0; end
      default: begin mul_a = quo; mul_b = s1; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      r0      <= coef_a[W-2:0];
      r1      <= coef_b[W-2:0];
      s0      <= W'(1);
      s1      <= '0;
      t0      <= '0;
      t1      <= W'(1);
      c_reg   <= rhs_c[W-1:0];
      ab_zero <= (coef_a[W-2:0] == '0) && (coef_b[W-2:0] == '0);
      c_zero  <= (rhs_c[W-1:0] == '0);
    end else if (cmd.step) begin
      r0 <= r1;
      r1 <= rem[W-2:0];
      s0 <= s1;
      s1 <= ns;
      t0 <= t1;
      t1 <= t0 - prod[W-1:0];
    end
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
    if (cmd.ns_en) begin
      ns <= s0 - prod[W-1:0];
    end
    if (cmd.x_en) begin
      xres <= prod;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.finish;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      divisor <= DIV_W'(r0);
      status  <= cmd.fin_status;
      if (cmd.fin_status == ST_SOLVED) begin
        sol_x <= SOL_W'(xres);
        sol_y <= SOL_W'(prod);
      end else begin
        sol_x <= '0;
        sol_y <= '0;
      end
    end
  end

  assign stat.ab_zero  = ab_zero;
  assign stat.c_zero   = c_zero;
  assign stat.r1_zero  = (r1 == '0);
  assign stat.div_done = div_done;
  assign stat.rem_zero = (rem == '0);

endmodule
`default_nettype wire

/* hw/rtl/lds_ctrl.sv */
// Controller: sequences Euclid steps, the final scaling and the result transfer.
`default_nettype none
module lds_ctrl
  import lds_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     start,
  output logic          busy,
  input  wire dp_stat_t stat,
  output dp_cmd_t       cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_EDIV_GO,
    S_EDIV_WAIT,
    S_MUL_S,
    S_MUL_T,
    S_STEP,
    S_CDIV_GO,
    S_CDIV_WAIT,
    S_MUL_X,
    S_MUL_Y,
    S_FINISH
  } state_t;

  state_t  state, state_next;
  status_t fin_status;

  assign busy = (state != S_IDLE);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (start) state_next = S_CHECK;
      S_CHECK: begin
        priority if (stat.ab_zero) state_next = S_FINISH;
        else if (stat.r1_zero)     state_next = S_CDIV_GO;
        else                       state_next = S_EDIV_GO;
      end
      S_EDIV_GO:   state_next = S_EDIV_WAIT;
      S_EDIV_WAIT: if (stat.div_done) state_next = S_MUL_S;
      S_MUL_S:     state_next = S_MUL_T;
      S_MUL_T:     state_next = S_STEP;
      S_STEP:      state_next = S_CHECK;
      S_CDIV_GO:   state_next = S_CDIV_WAIT;
      S_CDIV_WAIT: begin
        if (stat.div_done) state_next = stat.rem_zero ? S_MUL_X : S_FINISH;
      end
      S_MUL_X:     state_next = S_MUL_Y;
      S_MUL_Y:     state_next = S_FINISH;
      S_FINISH:    state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fin_status <= ST_SOLVED;
    end else begin
      state <= state_next;
      if (state == S_CHECK && stat.ab_zero) begin
        fin_status <= stat.c_zero ? ST_ALL : ST_NONE;
      end else if (state == S_CDIV_WAIT && stat.div_done && !stat.rem_zero) begin
        fin_status <= ST_NONE;
      end else if (state == S_MUL_Y) begin
        fin_status <= ST_SOLVED;
      end
    end
  end

  always_comb begin
    cmd            = '0;
    cmd.mul_sel    = MUL_S1;
    cmd.fin_status = fin_status;
    cmd.load       = (state == S_IDLE) && start;
    unique case (state)
      S_EDIV_GO: cmd.div_go = 1'b1;
      S_MUL_S: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_S1;
      end
      S_MUL_T: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_T1;
        cmd.ns_en   = 1'b1;
      end
      S_STEP: cmd.step = 1'b1;
      S_CDIV_GO: begin
        cmd.div_go  = 1'b1;
        cmd.div_rhs = 1'b1;
      end
      S_CDIV_WAIT: cmd.div_rhs = 1'b1;
      S_MUL_X: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_S0;
        cmd.div_rhs = 1'b1;
      end
      S_MUL_Y: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_T0;
        cmd.div_rhs = 1'b1;
        cmd.x_en    = 1'b1;
      end
      S_FINISH: cmd.finish = 1'b1;
      default: ;
    endcase
  end

  a_start_goes_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> state == S_CHECK)
    else $error("accepted transfer did not start the sequence");

  a_div_done_waiting: assert property (@(posedge clk) disable iff (rst)
    stat.div_done |-> (state == S_EDIV_WAIT || state == S_CDIV_WAIT))
    else $error("divider finished while controller was not waiting");

  a_step_nonzero: assert property (@(posedge clk) disable iff (rst)
    state == S_STEP |-> !stat.r1_zero)
    else $error("Euclid step with zero divisor");

  a_rhs_div_gcd: assert property (@(posedge clk) disable iff (rst)
    state == S_CDIV_GO |-> stat.r1_zero && !stat.ab_zero)
    else $error("scaling division started before gcd was settled");

endmodule
`default_nettype wire

/* hw/rtl/linear_diophantine_solver_top.sv */
// Each Euclid step costs one pass of the bit-serial divider plus the multiply and step states;
// the final c/g division adds one more pass and skips both multiplies when g does not divide c.
// a = b = 0 skips the divider and goes straight to the result.
// Throughput: one transfer at a time; start is taken again from the done cycle on, receiver can't stall.
// Synchronous active-high rst returns the controller to idle and clears done.
`default_nettype none
module linear_diophantine_solver_top
  import lds_pkg::*;
#(
  parameter int WIDTH = LDS_WIDTH
) (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    start,
  output logic                         busy,
  input  wire logic [COEF_W-1:0]       coef_a,
  input  wire logic [COEF_W-1:0]       coef_b,
  input  wire logic signed [RHS_W-1:0] rhs_c,
  output logic                         done,
  output logic [DIV_W-1:0]             divisor,
  output logic signed [SOL_W-1:0]      sol_x,
  output logic signed [SOL_W-1:0]      sol_y,
  output logic [STATUS_W-1:0]          status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  lds_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  lds_datapath #(.W(WIDTH)) u_dp (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd),
    .stat    (stat),
    .coef_a  (coef_a),
    .coef_b  (coef_b),
    .rhs_c   (rhs_c),
    .done    (done),
    .divisor (divisor),
    .sol_x   (sol_x),
    .sol_y   (sol_y),
    .status  (status)
  );

endmodule
`default_nettype wire
